// ===== rtl/core/hrrtp_pkg.sv =====
// ----------------------------------------------------------------------------
// hrrtp_pkg
// Shared types and constants of the hierarchical round-robin task picker.
// ----------------------------------------------------------------------------
`default_nettype none

package hrrtp_pkg;

  // field widths
  localparam int GROUP_W = 2;
  localparam int INDEX_W = 4;
  localparam int SEL_W   = 16;
  localparam int SPIN_W  = 2;
  localparam int CNT_W   = INDEX_W + 1;

  // stream word widths
  localparam int IN_W  = 24;
  localparam int OUT_W = 32;

  // task memory: one row of sixteen slots per group
  localparam int GROUP_SLOTS = 16;
  localparam int MEM_DEPTH   = 3 * GROUP_SLOTS;
  localparam int ADDR_W      = GROUP_W + INDEX_W;

  // group codes
  localparam logic [GROUP_W-1:0] GRP_A      = 2'd0;
  localparam logic [GROUP_W-1:0] GRP_B      = 2'd1;
  localparam logic [GROUP_W-1:0] GRP_SHARED = 2'd2;

  localparam logic [SEL_W-1:0] IDLE_SELECTOR_RESET = 16'h0050;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } state_t;

  // kind of result an accepted item produces
  typedef enum logic [1:0] {
    RES_NONE,
    RES_IDLE,
    RES_PICK
  } res_t;

  // table entry write toward the scheduler
  typedef struct packed {
    logic               en;
    logic [GROUP_W-1:0] group;
    logic [INDEX_W-1:0] index;
    logic               alive;
  } entry_wr_t;

  // candidate pick from the scheduler
  typedef struct packed {
    logic               valid;
    logic [GROUP_W-1:0] group;
    logic [INDEX_W-1:0] index;
  } pick_t;

  function automatic logic [ADDR_W-1:0] mem_addr(input logic [GROUP_W-1:0] group,
                                                 input logic [INDEX_W-1:0] index);
    mem_addr = {group, index};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hrrtp_task_mem.sv =====
// ----------------------------------------------------------------------------
// hrrtp_task_mem
// Selector and spinner memories, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrtp_task_mem (
  input  wire logic                         clk,
  input  wire logic                         sel_we,
  input  wire logic                         spin_we,
  input  wire logic [hrrtp_pkg::ADDR_W-1:0] wr_addr,
  input  wire logic [hrrtp_pkg::SEL_W-1:0]  sel_wdata,
  input  wire logic [hrrtp_pkg::SPIN_W-1:0] spin_wdata,
  input  wire logic                         rd_en,
  input  wire logic [hrrtp_pkg::ADDR_W-1:0] rd_addr,
  output logic      [hrrtp_pkg::SEL_W-1:0]  rd_sel,
  output logic      [hrrtp_pkg::SPIN_W-1:0] rd_spin
);

  logic [hrrtp_pkg::SEL_W-1:0]  sel_mem  [0:hrrtp_pkg::MEM_DEPTH-1];
  logic [hrrtp_pkg::SPIN_W-1:0] spin_mem [0:hrrtp_pkg::MEM_DEPTH-1];

  // write port
  always_ff @(posedge clk) begin
    if (sel_we) begin
      sel_mem[wr_addr] <= sel_wdata;
    end
    if (spin_we) begin
      spin_mem[wr_addr] <= spin_wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_sel  <= sel_mem[rd_addr];
      rd_spin <= spin_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hrrtp_sched.sv =====
// ----------------------------------------------------------------------------
// hrrtp_sched
// Alive bits, group pointers and the running group; picks the next live slot.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrtp_sched #(
  parameter int SHARED_SLOTS = 16,
  parameter int PLAYER_SLOTS = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire hrrtp_pkg::entry_wr_t          wr,
  input  wire logic                          pick_en,
  output hrrtp_pkg::pick_t                   pick,
  output logic      [hrrtp_pkg::GROUP_W-1:0] run_group,
  output logic      [hrrtp_pkg::INDEX_W-1:0] run_index
);

  logic [SHARED_SLOTS-1:0] shared_alive;
  logic [PLAYER_SLOTS-1:0] alive_a;
  logic [PLAYER_SLOTS-1:0] alive_b;
  logic [hrrtp_pkg::INDEX_W-1:0] shared_ptr;
  logic [hrrtp_pkg::INDEX_W-1:0] ptr_a;
  logic [hrrtp_pkg::INDEX_W-1:0] ptr_b;

  logic [hrrtp_pkg::GROUP_SLOTS-1:0] live_a;
  logic [hrrtp_pkg::GROUP_SLOTS-1:0] live_b;
  logic [hrrtp_pkg::GROUP_SLOTS-1:0] live_s;
  logic [2:0]                        has_live;
  logic [hrrtp_pkg::GROUP_W-1:0]     grp_nx;
  logic [hrrtp_pkg::GROUP_W-1:0]     grp_nn;
  logic [hrrtp_pkg::GROUP_SLOTS-1:0] cand_vec;
  logic [hrrtp_pkg::INDEX_W-1:0]     cand_ptr;
  logic [hrrtp_pkg::CNT_W-1:0]       cand_n;
  logic                              pick_valid;
  logic [hrrtp_pkg::GROUP_W-1:0]     pick_group;
  logic [hrrtp_pkg::INDEX_W-1:0]     pick_index;

  function automatic logic [hrrtp_pkg::GROUP_W-1:0] group_after(
      input logic [hrrtp_pkg::GROUP_W-1:0] g);
    group_after = (g == hrrtp_pkg::GRP_SHARED) ? hrrtp_pkg::GRP_A
                                               : g + hrrtp_pkg::GROUP_W'(1);
  endfunction

  // alive bits widened to a full group row
  always_comb begin
    live_a = '0;
    live_b = '0;
    live_s = '0;
    for (int i = 0; i < PLAYER_SLOTS; i++) begin
      live_a[i] = alive_a[i];
      live_b[i] = alive_b[i];
    end
    for (int i = 0; i < SHARED_SLOTS; i++) begin
      live_s[i] = shared_alive[i];
    end
  end

  assign has_live = {|live_s, |live_b, |live_a};
  assign grp_nx   = group_after(run_group);
  assign grp_nn   = group_after(grp_nx);

  // group order: next, next-but-one, then the running one
  always_comb begin
    pick_valid = 1'b1;
    if (has_live[grp_nx]) begin
      pick_group = grp_nx;
    end else if (has_live[grp_nn]) begin
      pick_group = grp_nn;
    end else begin
      pick_group = run_group;
      pick_valid = has_live[run_group];
    end
  end

  // row, pointer and size of the chosen group
  always_comb begin
    unique case (pick_group)
      hrrtp_pkg::GRP_A: begin
        cand_vec = live_a;
        cand_ptr = ptr_a;
        cand_n   = hrrtp_pkg::CNT_W'(PLAYER_SLOTS);
      end
      hrrtp_pkg::GRP_B: begin
        cand_vec = live_b;
        cand_ptr = ptr_b;
        cand_n   = hrrtp_pkg::CNT_W'(PLAYER_SLOTS);
      end
      default: begin
        cand_vec = live_s;
        cand_ptr = shared_ptr;
        cand_n   = hrrtp_pkg::CNT_W'(SHARED_SLOTS);
      end
    endcase
  end

  // rotating priority encode: first live slot after the pointer
  always_comb begin
    logic [hrrtp_pkg::CNT_W-1:0] idx;
    logic                        found;
    found      = 1'b0;
    pick_index = cand_ptr;
    for (int k = 1; k <= hrrtp_pkg::GROUP_SLOTS; k++) begin
      idx = {1'b0, cand_ptr} + hrrtp_pkg::CNT_W'(k);
      if (idx >= cand_n) begin
        idx = idx - cand_n;
      end
      if (!found && (hrrtp_pkg::CNT_W'(k) <= cand_n) &&
          cand_vec[idx[hrrtp_pkg::INDEX_W-1:0]]) begin
        found      = 1'b1;
        pick_index = idx[hrrtp_pkg::INDEX_W-1:0];
      end
    end
  end

  assign pick = {pick_valid, pick_group, pick_index};

  // pointer of the running group
  always_comb begin
    unique case (run_group)
      hrrtp_pkg::GRP_A: run_index = ptr_a;
      hrrtp_pkg::GRP_B: run_index = ptr_b;
      default:          run_index = shared_ptr;
    endcase
  end

  // alive bit writes
  always_ff @(posedge clk) begin
    if (rst) begin
      shared_alive <= '0;
      alive_a      <= '0;
      alive_b      <= '0;
    end else if (wr.en) begin
      for (int i = 0; i < SHARED_SLOTS; i++) begin
        if (wr.group == hrrtp_pkg::GRP_SHARED && wr.index == hrrtp_pkg::INDEX_W'(i)) begin
          shared_alive[i] <= wr.alive;
        end
      end
      for (int i = 0; i < PLAYER_SLOTS; i++) begin
        if (wr.group == hrrtp_pkg::GRP_A && wr.index == hrrtp_pkg::INDEX_W'(i)) begin
          alive_a[i] <= wr.alive;
        end
        if (wr.group == hrrtp_pkg::GRP_B && wr.index == hrrtp_pkg::INDEX_W'(i)) begin
          alive_b[i] <= wr.alive;
        end
      end
    end
  end

  // pointer and running group update on a pick
  always_ff @(posedge clk) begin
    if (rst) begin
      run_group  <= hrrtp_pkg::GRP_SHARED;
      shared_ptr <= '0;
      ptr_a      <= '0;
      ptr_b      <= '0;
    end else if (pick_en && pick_valid) begin
      run_group <= pick_group;
      unique case (pick_group)
        hrrtp_pkg::GRP_A: ptr_a      <= pick_index;
        hrrtp_pkg::GRP_B: ptr_b      <= pick_index;
        default:          shared_ptr <= pick_index;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hierarchical_round_robin_task_picker.sv =====
// Each word is accepted in IDLE; its result is written into the output register in FINISH.
// A new word is not taken until the last one has finished; a tick needs one task memory read before its result.
// A stalled output holds the finishing word and the input waits behind it.
// Reset (rst, synchronous): alive bits and pointers clear, running group is shared,
// idle flag set, idle selector 0x50; task memories are not cleared.
// ----------------------------------------------------------------------------
// hierarchical_round_robin_task_picker
// Two-level round-robin picker over player A, player B and shared task groups.
// ----------------------------------------------------------------------------
`default_nettype none

module hierarchical_round_robin_task_picker #(
  parameter int SHARED_SLOTS = 16,
  parameter int PLAYER_SLOTS = 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [hrrtp_pkg::SEL_W-1:0]  cfg_wdata,   // idle_selector
  input  wire logic                         s_tvalid,
  output logic                              s_tready,
  // halt, entry_group, entry_index, entry_alive, entry_selector
  input  wire logic [hrrtp_pkg::IN_W-1:0]   s_tdata,
  input  wire logic                         s_tuser,     // kind
  output logic                              m_tvalid,
  input  wire logic                         m_tready,
  // next_selector, chosen_group, chosen_index, spinner_phase, picked, went_idle
  output logic      [hrrtp_pkg::OUT_W-1:0]  m_tdata
);

  hrrtp_pkg::state_t state;
  hrrtp_pkg::state_t state_next;
  hrrtp_pkg::res_t   res_op;
  hrrtp_pkg::res_t   res_op_next;

  logic                           idle_flag;
  logic [hrrtp_pkg::SEL_W-1:0]    last_selector;
  logic [hrrtp_pkg::SEL_W-1:0]    idle_selector;
  logic [hrrtp_pkg::ADDR_W-1:0]   spin_addr;

  logic                           accept;
  logic                           commit;
  logic                           kind;
  logic                           halt;
  logic [hrrtp_pkg::GROUP_W-1:0]  entry_group;
  logic [hrrtp_pkg::INDEX_W-1:0]  entry_index;
  logic                           entry_alive;
  logic [hrrtp_pkg::SEL_W-1:0]    entry_selector;
  logic                           target_ok;
  logic                           pick_en;

  hrrtp_pkg::entry_wr_t           wr;
  hrrtp_pkg::pick_t               pick;
  logic [hrrtp_pkg::GROUP_W-1:0]  run_group;
  logic [hrrtp_pkg::INDEX_W-1:0]  run_index;

  logic                           spin_we;
  logic [hrrtp_pkg::ADDR_W-1:0]   wr_addr;
  logic [hrrtp_pkg::SPIN_W-1:0]   spin_wdata;
  logic [hrrtp_pkg::SEL_W-1:0]    rd_sel;
  logic [hrrtp_pkg::SPIN_W-1:0]   rd_spin;
  logic [hrrtp_pkg::SPIN_W-1:0]   spin_inc;
  logic [hrrtp_pkg::SEL_W-1:0]    cmp_sel;

  logic [hrrtp_pkg::SEL_W-1:0]    res_sel;
  logic [hrrtp_pkg::SPIN_W-1:0]   res_spin;
  logic                           res_picked;
  logic                           res_idle;

  // input word fields
  assign kind           = s_tuser;
  assign halt           = s_tdata[0];
  assign entry_group    = s_tdata[2:1];
  assign entry_index    = s_tdata[6:3];
  assign entry_alive    = s_tdata[7];
  assign entry_selector = s_tdata[23:8];

  assign accept = s_tvalid && s_tready;

  // write target check against the group's slot count
  always_comb begin
    unique case (entry_group) inside
      hrrtp_pkg::GRP_A, hrrtp_pkg::GRP_B:
        target_ok = {1'b0, entry_index} < hrrtp_pkg::CNT_W'(PLAYER_SLOTS);
      hrrtp_pkg::GRP_SHARED:
        target_ok = {1'b0, entry_index} < hrrtp_pkg::CNT_W'(SHARED_SLOTS);
      default:
        target_ok = 1'b0;
    endcase
  end

  always_comb begin
    wr.en    = accept && kind && target_ok;
    wr.group = entry_group;
    wr.index = entry_index;
    wr.alive = entry_alive;
  end

  assign pick_en = accept && !kind && !halt;

  // result kind decided at accept
  always_comb begin
    if (kind || halt) begin
      res_op_next = hrrtp_pkg::RES_NONE;
    end else if (pick.valid) begin
      res_op_next = hrrtp_pkg::RES_PICK;
    end else if (!idle_flag) begin
      res_op_next = hrrtp_pkg::RES_IDLE;
    end else begin
      res_op_next = hrrtp_pkg::RES_NONE;
    end
  end

  hrrtp_sched #(
    .SHARED_SLOTS (SHARED_SLOTS),
    .PLAYER_SLOTS (PLAYER_SLOTS)
  ) u_sched (
    .clk       (clk),
    .rst       (rst),
    .wr        (wr),
    .pick_en   (pick_en),
    .pick      (pick),
    .run_group (run_group),
    .run_index (run_index)
  );

  // spinner write: entry reset at accept, increment at finish
  assign spin_inc   = rd_spin + hrrtp_pkg::SPIN_W'(1);
  assign spin_we    = wr.en || (commit && res_op == hrrtp_pkg::RES_PICK);
  assign wr_addr    = (state == hrrtp_pkg::ST_FINISH) ?
                      spin_addr : hrrtp_pkg::mem_addr(entry_group, entry_index);
  assign spin_wdata = (state == hrrtp_pkg::ST_FINISH) ? spin_inc : '0;

  hrrtp_task_mem u_mem (
    .clk        (clk),
    .sel_we     (wr.en),
    .spin_we    (spin_we),
    .wr_addr    (wr_addr),
    .sel_wdata  (entry_selector),
    .spin_wdata (spin_wdata),
    .rd_en      (pick_en && pick.valid),
    .rd_addr    (hrrtp_pkg::mem_addr(pick.group, pick.index)),
    .rd_sel     (rd_sel),
    .rd_spin    (rd_spin)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hrrtp_pkg::ST_IDLE:   if (accept) state_next = hrrtp_pkg::ST_FINISH;
      hrrtp_pkg::ST_FINISH: if (commit) state_next = hrrtp_pkg::ST_IDLE;
      default:              state_next = hrrtp_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    commit   = 1'b0;
    unique case (state)
      hrrtp_pkg::ST_IDLE:   s_tready = 1'b1;
      hrrtp_pkg::ST_FINISH: commit   = !m_tvalid || m_tready;
      default:              s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hrrtp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item context carried to the finish cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      res_op    <= res_op_next;
      spin_addr <= hrrtp_pkg::mem_addr(pick.group, pick.index);
    end
  end

  // result fields
  assign cmp_sel = idle_flag ? '0 : last_selector;

  always_comb begin
    res_sel    = '0;
    res_spin   = '0;
    res_picked = 1'b0;
    res_idle   = 1'b0;
    unique case (res_op)
      hrrtp_pkg::RES_PICK: begin
        res_sel    = (rd_sel == cmp_sel) ? '0 : rd_sel;
        res_spin   = spin_inc;
        res_picked = 1'b1;
      end
      hrrtp_pkg::RES_IDLE: begin
        res_sel  = idle_selector;
        res_idle = 1'b1;
      end
      default: res_sel = '0;
    endcase
  end

  // last selector and idle flag
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_flag     <= 1'b1;
      last_selector <= '0;
    end else if (commit) begin
      if (res_op == hrrtp_pkg::RES_PICK) begin
        idle_flag     <= 1'b0;
        last_selector <= rd_sel;
      end else if (res_op == hrrtp_pkg::RES_IDLE) begin
        idle_flag <= 1'b1;
      end
    end
  end

  // idle selector register
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_selector <= hrrtp_pkg::IDLE_SELECTOR_RESET;
    end else if (cfg_we) begin
      idle_selector <= cfg_wdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_tdata <= {6'b0, res_idle, res_picked, res_spin, run_index, run_group, res_sel};
    end
  end

endmodule

`default_nettype wire

// ===== verif/hrrtp_checker.sv =====
// ----------------------------------------------------------------------------
// hrrtp_checker
// Watches the config port and both stream channels of the task picker, keeps
// its own copy of the group tables, pointers and idle state, predicts one
// result word per accepted input word and compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module hrrtp_checker
  import hrrtp_pkg::*;
#(
  parameter int SHARED_SLOTS = 16,
  parameter int PLAYER_SLOTS = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [SEL_W-1:0] cfg_wdata,
  input  wire logic             s_tvalid,
  input  wire logic             s_tready,
  input  wire logic [IN_W-1:0]  s_tdata,
  input  wire logic             s_tuser,
  input  wire logic             m_tvalid,
  input  wire logic             m_tready,
  input  wire logic [OUT_W-1:0] m_tdata,
  output int                    mismatches,
  output int                    pending
);

  // result word, lowest field last
  typedef struct packed {
    logic               went_idle;
    logic               picked;
    logic [SPIN_W-1:0]  spin;
    logic [INDEX_W-1:0] index;
    logic [GROUP_W-1:0] group;
    logic [SEL_W-1:0]   sel;
  } sched_result_t;

  localparam int RES_BITS = $bits(sched_result_t);

  // predicted scheduler state
  logic [GROUP_W-1:0] run_group;
  logic [INDEX_W-1:0] group_ptr [3];
  logic               slot_alive [3][GROUP_SLOTS];
  logic [SEL_W-1:0]   sel_mem [3][GROUP_SLOTS];
  logic [SPIN_W-1:0]  spin_mem [3][GROUP_SLOTS];
  logic [SEL_W-1:0]   last_sel;
  logic [SEL_W-1:0]   idle_sel;
  logic               idle_flag;

  sched_result_t expected_picks [$];
  int            word_no;

  initial begin
    mismatches = 0;
    pending    = 0;
    word_no    = 0;
  end

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned seen);
    $display("checker: result word %0d, %s: expected 0x%0h, got 0x%0h",
             word_no, field, want, seen);
    mismatches++;
  endtask

  function automatic int slots_of(input logic [GROUP_W-1:0] g);
    return (g == GRP_SHARED) ? SHARED_SLOTS : PLAYER_SLOTS;
  endfunction

  function automatic logic has_live(input logic [GROUP_W-1:0] g);
    for (int i = 0; i < slots_of(g); i++)
      if (slot_alive[g][i]) return 1'b1;
    return 1'b0;
  endfunction

  // circular group order: A, B, shared
  function automatic logic [GROUP_W-1:0] group_after(input logic [GROUP_W-1:0] g);
    case (g)
      GRP_A:   return GRP_B;
      GRP_B:   return GRP_SHARED;
      default: return GRP_A;
    endcase
  endfunction

  // one scheduling step for an accepted input word
  function automatic sched_result_t schedule_step(input logic is_write, input logic halt,
                                                  input logic [GROUP_W-1:0] eg,
                                                  input logic [INDEX_W-1:0] ei,
                                                  input logic ea,
                                                  input logic [SEL_W-1:0] es);
    sched_result_t      r;
    logic [GROUP_W-1:0] nx, nn, g;
    logic               found;
    logic [SEL_W-1:0]   cmp, s;
    int                 n, p;
    r     = '0;
    found = 1'b0;
    g     = run_group;
    if (is_write) begin
      // writes outside the group or its slot count are dropped
      if (eg <= GRP_SHARED && int'(ei) < slots_of(eg)) begin
        slot_alive[eg][ei] = ea;
        sel_mem[eg][ei]    = es;
        spin_mem[eg][ei]   = '0;
      end
    end else if (!halt) begin
      nx = group_after(run_group);
      nn = group_after(nx);
      if (has_live(nx)) begin
        g = nx; found = 1'b1;
      end else if (has_live(nn)) begin
        g = nn; found = 1'b1;
      end else if (has_live(run_group)) begin
        g = run_group; found = 1'b1;
      end
      if (found) begin
        // step the pointer to the next live slot, wrapping
        cmp = idle_flag ? '0 : last_sel;
        n   = slots_of(g);
        p   = int'(group_ptr[g]);
        for (int k = 0; k < n; k++) begin
          p = p + 1;
          if (p >= n) p = 0;
          if (slot_alive[g][p]) break;
        end
        group_ptr[g]     = p[INDEX_W-1:0];
        s                = sel_mem[g][p];
        run_group        = g;
        r.sel            = (s == cmp) ? '0 : s;
        last_sel         = s;
        idle_flag        = 1'b0;
        spin_mem[g][p]   = spin_mem[g][p] + 1'b1;
        r.spin           = spin_mem[g][p];
        r.picked         = 1'b1;
      end else if (!idle_flag) begin
        idle_flag   = 1'b1;
        r.sel       = idle_sel;
        r.went_idle = 1'b1;
      end
    end
    r.group = run_group;
    r.index = group_ptr[run_group];
    return r;
  endfunction

  // channel monitor: compare first, then predict, since a word accepted now
  // cannot have its result on the output in the same cycle
  always @(posedge clk) begin
    sched_result_t want, seen;
    if (rst) begin
      run_group = GRP_SHARED;
      for (int g = 0; g < 3; g++) begin
        group_ptr[g] = '0;
        for (int i = 0; i < GROUP_SLOTS; i++) slot_alive[g][i] = 1'b0;
      end
      last_sel  = '0;
      idle_sel  = IDLE_SELECTOR_RESET;
      idle_flag = 1'b1;
      expected_picks.delete();
    end else begin
      if (cfg_we) idle_sel = cfg_wdata;
      if (m_tvalid && m_tready) begin
        seen = m_tdata[RES_BITS-1:0];
        if (expected_picks.size() == 0) begin
          report_mismatch("word with nothing expected", 0, m_tdata);
        end else begin
          want = expected_picks.pop_front();
          if (seen.sel != want.sel)
            report_mismatch("next_selector", 32'(want.sel), 32'(seen.sel));
          if (seen.group != want.group)
            report_mismatch("chosen_group", 32'(want.group), 32'(seen.group));
          if (seen.index != want.index)
            report_mismatch("chosen_index", 32'(want.index), 32'(seen.index));
          if (seen.spin != want.spin)
            report_mismatch("spinner_phase", 32'(want.spin), 32'(seen.spin));
          if (seen.picked != want.picked)
            report_mismatch("picked", 32'(want.picked), 32'(seen.picked));
          if (seen.went_idle != want.went_idle)
            report_mismatch("went_idle", 32'(want.went_idle), 32'(seen.went_idle));
          if (m_tdata[OUT_W-1:RES_BITS] != '0)
            report_mismatch("padding", 0, 32'(m_tdata[OUT_W-1:RES_BITS]));
        end
        word_no++;
      end
      // s_tdata: halt, entry_group, entry_index, entry_alive, entry_selector
      if (s_tvalid && s_tready)
        expected_picks.push_back(schedule_step(s_tuser, s_tdata[0], s_tdata[2:1],
                                               s_tdata[6:3], s_tdata[7], s_tdata[23:8]));
    end
    pending <= expected_picks.size();
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives the task picker with directed table writes and ticks, then random
// traffic in phases with different idle selectors, random sender gaps and
// receiver stalls; the checker predicts and compares every result word.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
  import hrrtp_pkg::*;

  localparam int SHARED_SLOTS = 16;
  localparam int PLAYER_SLOTS = 8;
  localparam int QUIET_LIMIT  = 1000;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [SEL_W-1:0] cfg_wdata;
  logic             s_tvalid;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata;
  logic             s_tuser;
  logic             m_tvalid;
  logic             m_tready;
  logic [OUT_W-1:0] m_tdata;
  int               mismatches;
  int               pending;

  bit               idle_on;
  int               alive_pct;
  int               words_sent;
  int               quiet_cycles;
  bit               task_live [3][GROUP_SLOTS];
  logic [SEL_W-1:0] sel_pool [4];

  hierarchical_round_robin_task_picker #(
    .SHARED_SLOTS (SHARED_SLOTS),
    .PLAYER_SLOTS (PLAYER_SLOTS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  hrrtp_checker #(
    .SHARED_SLOTS (SHARED_SLOTS),
    .PLAYER_SLOTS (PLAYER_SLOTS)
  ) u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // receiver: random stall bursts while idling is on
  initial begin
    int hold;
    hold     = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        m_tready <= 1'b0;
        hold--;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        hold = $urandom_range(0, 2);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  // one word on the input stream, with an optional gap in front
  task automatic send_word(input logic is_write, input logic [IN_W-1:0] data);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= is_write;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic int slot_limit(input logic [GROUP_W-1:0] g);
    return (g == GRP_SHARED) ? SHARED_SLOTS : PLAYER_SLOTS;
  endfunction

  // table write; the halt bit is don't-care here and gets noise
  task automatic write_entry(input logic [GROUP_W-1:0] g, input logic [INDEX_W-1:0] idx,
                             input logic alive, input logic [SEL_W-1:0] sel);
    send_word(1'b1, {sel, alive, idx, g, 1'($urandom)});
    if (g <= GRP_SHARED && int'(idx) < slot_limit(g)) begin
      task_live[g][idx] = alive;
      words_sent++;
    end
  endtask

  // tick; the write fields are don't-care and get noise
  task automatic tick(input logic halt);
    send_word(1'b0, {16'($urandom), 1'($urandom), 4'($urandom), 2'($urandom), halt});
    words_sent++;
  endtask

  function automatic logic [SEL_W-1:0] pick_sel();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3, 4: return sel_pool[$urandom_range(0, 3)];
      default: return SEL_W'($urandom);
    endcase
  endfunction

  // kill every live slot, then tick into idle and past it
  task automatic kill_all_tasks();
    for (int g = 0; g < 3; g++)
      for (int i = 0; i < GROUP_SLOTS; i++)
        if (task_live[g][i]) write_entry(GROUP_W'(g), INDEX_W'(i), 1'b0, pick_sel());
    repeat (3) tick(1'b0);
  endtask

  // hold the sender until every result is back, then let the block settle
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_idle_selector(input logic [SEL_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random traffic: mostly ticks and valid writes, some dropped writes
  task automatic run_chunk(input int n, input bit allow_idle);
    int goal, step, r;
    logic [GROUP_W-1:0] g;
    goal = words_sent + n;
    step = 0;
    while (words_sent < goal) begin
      if (step % 25 == 0) begin
        idle_on = allow_idle && ($urandom_range(0, 3) != 0);
        case ($urandom_range(0, 2))
          0:       alive_pct = 20;
          1:       alive_pct = 55;
          default: alive_pct = 90;
        endcase
      end
      step++;
      r = $urandom_range(0, 99);
      if (r < 2) begin
        drain();
      end else if (r < 4) begin
        kill_all_tasks();
      end else if (r < 48) begin
        tick($urandom_range(0, 7) == 0);
      end else if (r < 52) begin
        // dropped writes: no such group, or a player slot past the end
        if ($urandom_range(0, 1) == 0)
          send_word(1'b1, {pick_sel(), 1'($urandom), 4'($urandom), 2'd3, 1'($urandom)});
        else
          send_word(1'b1, {pick_sel(), 1'($urandom),
                           4'($urandom_range(PLAYER_SLOTS, GROUP_SLOTS - 1)),
                           1'b0, 1'($urandom), 1'($urandom)});
      end else begin
        g = GROUP_W'($urandom_range(0, 2));
        write_entry(g, INDEX_W'($urandom_range(0, slot_limit(g) - 1)),
                    $urandom_range(0, 99) < alive_pct, pick_sel());
      end
    end
  endtask

  // stimulus and verdict
  initial begin
    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = 1'b0;
    idle_on    = 1'b1;
    alive_pct  = 50;
    words_sent = 0;
    for (int g = 0; g < 3; g++)
      for (int i = 0; i < GROUP_SLOTS; i++) task_live[g][i] = 1'b0;
    for (int i = 0; i < 4; i++) sel_pool[i] = SEL_W'($urandom);
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: ticks with nothing alive
    tick(1'b0);
    tick(1'b1);
    // a task in every group, slot extremes, a zero selector
    write_entry(GRP_A, INDEX_W'(0), 1'b1, 16'h1234);
    write_entry(GRP_B, INDEX_W'(PLAYER_SLOTS - 1), 1'b1, 16'hFFFF);
    write_entry(GRP_SHARED, INDEX_W'(SHARED_SLOTS - 1), 1'b1, 16'hABCD);
    write_entry(GRP_SHARED, INDEX_W'(0), 1'b1, 16'h0000);
    // dropped writes
    send_word(1'b1, {16'h5555, 1'b1, 4'(PLAYER_SLOTS), GRP_A, 1'b0});
    send_word(1'b1, {16'h5555, 1'b1, 4'hF, 2'd3, 1'b1});
    // rotation over the groups, then a halt
    repeat (6) tick(1'b0);
    tick(1'b1);
    // only group A left, two slots with one selector: repeat gives 0
    write_entry(GRP_B, INDEX_W'(PLAYER_SLOTS - 1), 1'b0, 16'h0001);
    write_entry(GRP_SHARED, INDEX_W'(SHARED_SLOTS - 1), 1'b0, 16'h0002);
    write_entry(GRP_SHARED, INDEX_W'(0), 1'b0, 16'h0003);
    write_entry(GRP_A, INDEX_W'(3), 1'b1, 16'h1234);
    repeat (5) tick(1'b0);
    // everything dead: idle selector once, then 0
    write_entry(GRP_A, INDEX_W'(0), 1'b0, 16'h0000);
    write_entry(GRP_A, INDEX_W'(3), 1'b0, 16'hFFFF);
    repeat (2) tick(1'b0);

    // random phases, each under its own idle selector
    drain();
    set_idle_selector(16'hFFFF);
    run_chunk(110, 1'b1);
    kill_all_tasks();
    drain();
    set_idle_selector(16'h0000);
    run_chunk(110, 1'b1);
    kill_all_tasks();
    drain();
    set_idle_selector(SEL_W'($urandom));
    run_chunk(110, 1'b1);
    kill_all_tasks();
    // closing stretch with no idling on either side
    run_chunk(30, 1'b0);

    drain();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
